### sv/filter_lock_arbiter_assert.svh
// Assertion helpers for the lock arbiter. Each use expands to one labeled
// concurrent assertion that reports through $error.
`ifndef FILTER_LOCK_ARBITER_ASSERT_SVH
`define FILTER_LOCK_ARBITER_ASSERT_SVH

// Same-cycle implication.
`define FLA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("filter_lock_arbiter: same-cycle check failed");

// Next-cycle implication.
`define FLA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("filter_lock_arbiter: next-cycle check failed");

`endif

### sv/fla_pkg.sv
package fla_pkg;

   localparam int PID_W  = 3;   // process id field
   localparam int ROOM_W = 3;   // room field and stored rooms
   localparam int CNT_W  = 4;   // process count register
   localparam int STS_W  = 3;   // status field
   localparam int DATA_W = 32;  // configuration data
   localparam int ADDR_W = 2;   // configuration byte address

   localparam logic [CNT_W-1:0]  PC_RESET = 4'd8;
   localparam logic [CNT_W-1:0]  PC_MIN   = 4'd2;
   localparam logic [ADDR_W-1:0] ADDR_PROCESS_COUNT = 2'd0;

   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_POLL    = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_BLOCKED  = 3'd0,
      STS_ADVANCED = 3'd1,
      STS_GRANTED  = 3'd2,
      STS_RELEASED = 3'd3,
      STS_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_SCAN,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic              start;
      logic [PID_W-1:0]  id;
      logic [ROOM_W-1:0] room;
      logic [CNT_W-1:0]  count;
   } scan_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } scan_stat_type;

endpackage

### sv/filter_lock_arbiter.sv
// filter_lock_arbiter: hardware lock unit running the filter form of
// Peterson's lock for up to eight processes.
// Request channel (req_*): one request carries an operation (request lock,
// poll, release) and a process id. A request is taken when req_valid is high
// and req_stall low; req_stall stays high while a request is in work.
// Response channel (rsp_*): exactly one response per request, carrying the
// status and the process's room after the step, taken when rsp_valid is high
// and rsp_stall low. A stalled response holds in the output register, and
// the unit still takes the next request; that request waits in its final
// step until the output register frees up.
// Sequence: a request passes through lookup, check, an optional room scan
// and apply. The scan visits at most as many slots as there are processes
// in use, and is skipped when no scan is needed. The response is loaded in
// the apply step. The scan compares one process's room per cycle
// through a single compare unit.
// Configuration: an APB-style port with one register, process_count at
// byte address 0. Writing it also returns every process to idle and clears
// the lock. Write it only while the unit is idle.
// Reset: synchronous, active high; process_count returns to 8, every process
// is idle and the lock is free. No clearing pass is needed.
module filter_lock_arbiter import fla_pkg::*; #(
   parameter int MAX_PROCESSES = 8
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [PID_W-1:0]  req_process_id,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STS_W-1:0]  rsp_status,
   output logic [ROOM_W-1:0] rsp_room,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

`include "filter_lock_arbiter_assert.svh"

   // slots actually stored: ids beyond this are never in use
   localparam int SLOTS  = (MAX_PROCESSES < 8) ? MAX_PROCESSES : 8;
   localparam int SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;

   state_type         state_ff, state_in;

   logic [CNT_W-1:0]  pc_ff;
   logic [CNT_W-1:0]  n_cnt;
   logic              cfg_wr;

   logic [ROOM_W-1:0] room_ff [SLOTS];
   logic [SLOT_W-1:0] last_ff [SLOTS];
   logic              lock_taken_ff;
   logic [SLOT_W-1:0] lock_owner_ff;

   logic [1:0]        op_ff;
   logic [PID_W-1:0]  id_ff;
   logic              id_ok_ff;
   logic [ROOM_W-1:0] r_ff;
   logic              hit_ff;

   logic              rsp_valid_ff;
   logic [STS_W-1:0]  rsp_status_ff;
   logic [ROOM_W-1:0] rsp_room_ff;

   logic              req_take;
   logic              rsp_take;
   logic              rsp_load;
   logic [SLOT_W-1:0] id_slot;
   logic [SLOT_W-1:0] rd_addr;
   logic [ROOM_W-1:0] room_rd;
   logic [SLOT_W-1:0] last_rd;
   logic              owner;
   logic              need_scan;
   logic [CNT_W-1:0]  r_next;

   // result of the current request and its write-back
   status_type        res_status;
   logic [ROOM_W-1:0] res_room;
   logic              wr_room_en;
   logic [ROOM_W-1:0] wr_room_val;
   logic              wr_last_en;
   logic [SLOT_W-1:0] wr_last_idx;
   logic              lock_set;
   logic              lock_clr;

   scan_ctrl_type     scan_ctrl;
   scan_stat_type     scan_stat;
   logic [SLOT_W-1:0] scan_slot;

   // ---------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign prdata = DATA_W'(pc_ff);
   assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_PROCESS_COUNT);

   // clamp the register to the number of stored slots, never below two
   always_comb begin
      if (pc_ff < PC_MIN) begin
         n_cnt = PC_MIN;
      end else if (pc_ff > CNT_W'(SLOTS)) begin
         n_cnt = CNT_W'(SLOTS);
      end else begin
         n_cnt = pc_ff;
      end
   end

   // ---------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------
   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_room   = rsp_room_ff;

   // ---------------------------------------------------------------
   // Single read port on the room table: own slot at lookup, scan slot later
   // ---------------------------------------------------------------
   assign id_slot = id_ff[SLOT_W-1:0];
   assign rd_addr = (state_ff == ST_SCAN) ? scan_slot : id_slot;
   assign room_rd = room_ff[rd_addr];
   assign last_rd = last_ff[r_ff[SLOT_W-1:0]];
   assign owner   = lock_taken_ff && (lock_owner_ff == id_slot);
   assign r_next  = CNT_W'(r_ff) + CNT_W'(1);

   // A poll needs the scan only when this process entered its room last.
   assign need_scan = id_ok_ff && (op_ff == OP_POLL) && (r_ff != '0) && !owner &&
                      (last_rd == id_slot);

   fla_scan #(
      .SLOT_W (SLOT_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .slot_room (room_rd),
      .slot      (scan_slot),
      .stat      (scan_stat)
   );

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_CHECK;
         ST_CHECK:  state_in = need_scan ? ST_SCAN : ST_APPLY;
         ST_SCAN:   if (scan_stat.done) state_in = ST_APPLY;
         ST_APPLY:  if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------
   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      scan_ctrl.start = (state_ff == ST_CHECK) && need_scan;
      scan_ctrl.id    = id_ff;
      scan_ctrl.room  = r_ff;
      scan_ctrl.count = n_cnt;
      // load the response only when the output register is free or leaving
      rsp_load        = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);
   end

   // ---------------------------------------------------------------
   // Decide the outcome from the gathered facts
   // ---------------------------------------------------------------
   always_comb begin
      res_status  = STS_IGNORED;
      res_room    = r_ff;
      wr_room_en  = 1'b0;
      wr_room_val = r_ff;
      wr_last_en  = 1'b0;
      wr_last_idx = SLOT_W'(1);
      lock_set    = 1'b0;
      lock_clr    = 1'b0;
      if (id_ok_ff) begin
         case (op_ff)
            OP_REQUEST: begin
               // enter room 1 from idle
               if (r_ff == '0) begin
                  res_status  = STS_ADVANCED;
                  res_room    = ROOM_W'(1);
                  wr_room_en  = 1'b1;
                  wr_room_val = ROOM_W'(1);
                  wr_last_en  = 1'b1;
                  wr_last_idx = SLOT_W'(1);
               end
            end
            OP_POLL: begin
               if (r_ff != '0) begin
                  if (owner) begin
                     res_status = STS_GRANTED;
                  end else if (!hit_ff) begin
                     if (r_next >= n_cnt) begin
                        // leaving the top room takes the lock; stay there
                        res_status = STS_GRANTED;
                        lock_set   = 1'b1;
                     end else begin
                        res_status  = STS_ADVANCED;
                        res_room    = ROOM_W'(r_next);
                        wr_room_en  = 1'b1;
                        wr_room_val = ROOM_W'(r_next);
                        wr_last_en  = 1'b1;
                        wr_last_idx = SLOT_W'(r_next);
                     end
                  end else begin
                     res_status = STS_BLOCKED;
                  end
               end
            end
            OP_RELEASE: begin
               if (r_ff != '0) begin
                  res_status  = STS_RELEASED;
                  res_room    = '0;
                  wr_room_en  = 1'b1;
                  wr_room_val = '0;
                  lock_clr    = owner;
               end
            end
            default: begin
               res_status = STS_IGNORED;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pc_ff         <= PC_RESET;
         lock_taken_ff <= 1'b0;
         lock_owner_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < SLOTS; k++) begin
            room_ff[k] <= '0;
            last_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg_wr) begin
            // new process count: drop every process back to idle, free the lock
            pc_ff         <= pwdata[CNT_W-1:0];
            lock_taken_ff <= 1'b0;
            lock_owner_ff <= '0;
            for (int k = 0; k < SLOTS; k++) begin
               room_ff[k] <= '0;
               last_ff[k] <= '0;
            end
         end else if (rsp_load) begin
            if (wr_room_en) room_ff[id_slot] <= wr_room_val;
            if (wr_last_en) last_ff[wr_last_idx] <= id_slot;
            if (lock_set) begin
               lock_taken_ff <= 1'b1;
               lock_owner_ff <= id_slot;
            end else if (lock_clr) begin
               lock_taken_ff <= 1'b0;
               lock_owner_ff <= '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Request context and response payload
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_operation;
         id_ff    <= req_process_id;
         id_ok_ff <= (CNT_W'(req_process_id) < n_cnt);
      end
      // ids out of range never hold a room
      if (state_ff == ST_LOOKUP) r_ff <= id_ok_ff ? room_rd : '0;
      if (state_ff == ST_CHECK) begin
         hit_ff <= 1'b0;
      end else if ((state_ff == ST_SCAN) && scan_stat.done) begin
         hit_ff <= scan_stat.hit;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_room_ff   <= res_room;
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `FLA_ASSERT_NXT(a_take_starts_lookup, clock, reset, req_take, state_ff == ST_LOOKUP)
   `FLA_ASSERT_IMP(a_scan_only_in_scan, clock, reset, scan_stat.busy, state_ff == ST_SCAN)
   `FLA_ASSERT_IMP(a_owner_in_top_room, clock, reset, lock_taken_ff,
                   CNT_W'(room_ff[lock_owner_ff]) == (n_cnt - CNT_W'(1)))

endmodule

### sv/fla_scan.sv
module fla_scan import fla_pkg::*; #(
   parameter int SLOT_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  scan_ctrl_type       ctrl,
   input  logic [ROOM_W-1:0]   slot_room,
   output logic [SLOT_W-1:0]   slot,
   output scan_stat_type       stat
);

   logic              busy_ff, busy_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [PID_W-1:0]  id_ff, id_in;
   logic [ROOM_W-1:0] room_ff, room_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              hit_now;
   logic              last_slot;

   // One slot per cycle through the shared compare: another live process at or above the room.
   always_comb begin
      hit_now   = busy_ff && (PID_W'(idx_ff) != id_ff) && (slot_room != '0) &&
                  (slot_room >= room_ff);
      last_slot = (CNT_W'(idx_ff) == (cnt_ff - CNT_W'(1)));
      stat.busy = busy_ff;
      stat.done = busy_ff && (hit_now || last_slot);
      stat.hit  = hit_now;
      slot      = idx_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      id_in   = id_ff;
      room_in = room_ff;
      cnt_in  = cnt_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         id_in   = ctrl.id;
         room_in = ctrl.room;
         cnt_in  = ctrl.count;
      end else if (busy_ff) begin
         // stop at the first hit or after the last slot in use
         busy_in = !stat.done;
         idx_in  = SLOT_W'(idx_ff + SLOT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      id_ff   <= id_in;
      room_ff <= room_in;
      cnt_ff  <= cnt_in;
   end

endmodule
